// File: rtl/core/rtu_pkg.sv
// rtu_pkg: shared constants and types of the frame receiver with crc check
// no dependencies; imported by rtu_cfg_if and every module in rtl/core

package rtu_pkg;

  // frame buffer sizing
  localparam int unsigned FRAME_DEPTH = 64;
  localparam int unsigned ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int unsigned CNT_W       = $clog2(FRAME_DEPTH + 1);

  // crc-16, reflected form
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // configuration registers
  localparam int unsigned CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ID = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAP      = CFG_IDX_W'(1);
  localparam logic [7:0]  GAP_RESET   = 8'd10;

  // input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // result kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // command to the bit-serial crc engine
  typedef struct packed {
    logic       start;    // fold a new byte
    logic       restart;  // begin from the init value
    logic [7:0] data;
  } crc_cmd_t;

  // status back from the crc engine
  typedef struct packed {
    logic        busy;
    logic [15:0] crc;
  } crc_stat_t;

endpackage

// File: rtl/core/rtu_ifs.sv
// rtu_ifs: valid/ready channels of the frame receiver (input, result, config)
// depends on rtu_pkg for the config index width

interface rtu_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface rtu_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output kind, output out_byte, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

interface rtu_cfg_if
  import rtu_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/rtu_frame_receiver_crc_check_unit.sv
// rtu_frame_receiver_crc_check_unit: top level, frame control and result output
// depends on rtu_pkg, rtu_ifs, rtu_crc and rtu_frame_buf

// Takes received bytes (op 0) and millisecond ticks (op 1) on rx_i. A byte
// is accepted, then folded by the bit-serial crc engine in eight polynomial
// steps, one step per cycle; no input item is taken while the engine is busy.
// When the silence after the last byte exceeds the gap register, the frame
// closes: frames shorter than three bytes, overflowed frames and frames for
// another address are dropped; a bad crc gives one error item carrying the
// function code; a good frame gives its bytes minus the crc, the first byte
// replaced by the payload length. Good-frame items leave one by one through
// S_EMIT and S_FETCH, paced by the registered read of the frame buffer; input is
// held off while a frame is being emitted. The last result item sits in the
// output register while the next input item is accepted.

module rtu_frame_receiver_crc_check_unit
  import rtu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  rtu_in_if.sink    rx_i,
  rtu_out_if.source res_o,
  rtu_cfg_if.sink   cfg_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EMIT  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_ERR   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [7:0]       slave_id_q, slave_id_d;
  logic [7:0]       gap_q, gap_d;
  logic             in_frame_q, in_frame_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       silence_q, silence_d;
  logic             ovf_q, ovf_d;
  logic [7:0]       id_q, id_d;
  logic [7:0]       fc_q, fc_d;
  logic [CNT_W-1:0] nlast_q, nlast_d;
  logic [CNT_W-1:0] idx_q, idx_d;

  logic             ovalid_q, ovalid_d;
  logic             okind_q, okind_d;
  logic [7:0]       obyte_q, obyte_d;
  logic             olast_q, olast_d;

  crc_cmd_t  crc_cmd;
  crc_stat_t crc_stat;

  logic             rx_take;
  logic             slot_free;
  logic [8:0]       silence_next;
  logic             buf_we;
  logic [7:0]       rdata;

  assign rx_i.ready  = (state_q == S_IDLE) && !crc_stat.busy;
  assign rx_take     = rx_i.valid && rx_i.ready;
  assign slot_free   = !ovalid_q || res_o.ready;
  assign cfg_i.ready = 1'b1;
  assign silence_next = {1'b0, silence_q} + 9'd1;

  // configuration register decode
  always_comb begin
    slave_id_d = slave_id_q;
    gap_d      = gap_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_SLAVE_ID: slave_id_d = cfg_i.data;
        REG_GAP:      gap_d      = cfg_i.data;
        default:      ;
      endcase
    end
  end

  // frame control and emission sequencer
  always_comb begin
    state_d    = state_q;
    in_frame_d = in_frame_q;
    count_d    = count_q;
    silence_d  = silence_q;
    ovf_d      = ovf_q;
    id_d       = id_q;
    fc_d       = fc_q;
    nlast_d    = nlast_q;
    idx_d      = idx_q;
    ovalid_d   = ovalid_q && !res_o.ready;
    okind_d    = okind_q;
    obyte_d    = obyte_q;
    olast_d    = olast_q;
    buf_we     = 1'b0;
    crc_cmd    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (rx_take && rx_i.op == OP_BYTE) begin
          // byte: open frame if needed, store, fold into crc
          crc_cmd.start   = 1'b1;
          crc_cmd.restart = !in_frame_q;
          crc_cmd.data    = rx_i.rx_byte;
          in_frame_d      = 1'b1;
          silence_d       = 8'd0;
          if (!in_frame_q) begin
            ovf_d   = 1'b0;
            buf_we  = 1'b1;
            id_d    = rx_i.rx_byte;
            count_d = CNT_W'(1);
          end else if (count_q < CNT_W'(FRAME_DEPTH)) begin
            buf_we  = 1'b1;
            count_d = count_q + CNT_W'(1);
            if (count_q == CNT_W'(1)) begin
              fc_d = rx_i.rx_byte;
            end
          end else begin
            ovf_d = 1'b1;
          end
        end else if (rx_take && in_frame_q) begin
          // tick inside a frame
          if (silence_next <= {1'b0, gap_q}) begin
            silence_d = silence_next[7:0];
          end else begin
            in_frame_d = 1'b0;
            silence_d  = 8'd0;
            count_d    = '0;
            ovf_d      = 1'b0;
            if (count_q < CNT_W'(3) || ovf_q || id_q != slave_id_q) begin
              state_d = S_IDLE;
            end else if (crc_stat.crc != 16'h0000) begin
              state_d = S_ERR;
            end else begin
              nlast_d = count_q - CNT_W'(3);
              idx_d   = '0;
              state_d = S_EMIT;
            end
          end
        end
      end
      S_ERR: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          okind_d  = KIND_ERROR;
          obyte_d  = fc_q;
          olast_d  = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          okind_d  = KIND_DATA;
          obyte_d  = (idx_q == '0) ? 8'(nlast_q) : rdata;
          olast_d  = (idx_q == nlast_q);
          if (idx_q == nlast_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        // buffer read at the new index is registered here, ready for S_EMIT
        state_d = S_EMIT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      slave_id_q <= 8'd0;
      gap_q      <= GAP_RESET;
      in_frame_q <= 1'b0;
      count_q    <= '0;
      silence_q  <= 8'd0;
      ovf_q      <= 1'b0;
      nlast_q    <= '0;
      idx_q      <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      slave_id_q <= slave_id_d;
      gap_q      <= gap_d;
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
      silence_q  <= silence_d;
      ovf_q      <= ovf_d;
      nlast_q    <= nlast_d;
      idx_q      <= idx_d;
      ovalid_q   <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    fc_q    <= fc_d;
    okind_q <= okind_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  rtu_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (crc_cmd),
    .stat_o (crc_stat)
  );

  rtu_frame_buf u_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (in_frame_q ? count_q[ADDR_W-1:0] : ADDR_W'(0)),
    .wdata_i (rx_i.rx_byte),
    .raddr_i (idx_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  // result channel
  assign res_o.valid    = ovalid_q;
  assign res_o.kind     = okind_q;
  assign res_o.out_byte = obyte_q;
  assign res_o.last     = olast_q;

endmodule

// File: rtl/core/rtu_crc.sv
// rtu_crc: bit-serial crc-16 engine, one polynomial step per cycle
// depends on rtu_pkg (crc constants, command and status structs)

module rtu_crc
  import rtu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  crc_cmd_t  cmd_i,
  output crc_stat_t stat_o
);

  logic [15:0] crc_q, crc_d;
  logic [2:0]  step_q, step_d;
  logic        busy_q, busy_d;

  // load the byte, then shift out eight bits
  always_comb begin
    crc_d  = crc_q;
    step_d = step_q;
    busy_d = busy_q;
    if (cmd_i.start) begin
      crc_d  = (cmd_i.restart ? CRC_INIT : crc_q) ^ {8'h00, cmd_i.data};
      step_d = 3'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      crc_d  = crc_q[0] ? ((crc_q >> 1) ^ CRC_POLY) : (crc_q >> 1);
      step_d = step_q + 3'd1;
      if (step_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CRC_INIT;
      step_q <= 3'd0;
      busy_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      step_q <= step_d;
      busy_q <= busy_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.crc  = crc_q;

endmodule

// File: rtl/core/rtu_frame_buf.sv
// rtu_frame_buf: frame byte store, one write port and one registered read port
// depends on rtu_pkg for depth and address width

module rtu_frame_buf
  import rtu_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem_q [FRAME_DEPTH];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: verif/rtu_frame_result_check.sv
// rtu_frame_result_check: watches the input, result and config channels of the
// frame receiver, predicts every result item and compares it field by field
// depends on rtu_pkg and rtu_ifs

module rtu_frame_result_check
  import rtu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rtu_in_if           rx_i,
  rtu_out_if          res_i,
  rtu_cfg_if          cfg_i,
  output int unsigned mismatches_o,
  output int unsigned waiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  // predicted receiver state
  logic [7:0]       frame_mem [FRAME_DEPTH];
  logic [CNT_W-1:0] frame_len;
  logic             open_frame;
  logic [7:0]       quiet_ticks;
  logic [15:0]      crc_acc;
  logic             overrun;
  logic [7:0]       addr_cfg;
  logic [7:0]       gap_cfg;
  result_t          pending_results [$];

  // one byte into the reflected crc-16
  function automatic logic [15:0] fold_crc(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // advance the predicted state by one input item, queue what it causes
  function automatic void receive_item(input logic op, input logic [7:0] b);
    logic [8:0]  quiet_next;
    int unsigned n;
    result_t     r;
    if (op == OP_BYTE) begin
      if (!open_frame) begin
        open_frame = 1'b1;
        frame_len  = '0;
        crc_acc    = CRC_INIT;
        overrun    = 1'b0;
      end
      if (frame_len < FRAME_DEPTH) begin
        frame_mem[frame_len[ADDR_W-1:0]] = b;
        frame_len++;
      end else begin
        overrun = 1'b1;
      end
      crc_acc     = fold_crc(crc_acc, b);
      quiet_ticks = '0;
      return;
    end
    if (!open_frame) return;
    // silence compared one bit wider so a gap of 255 still closes
    quiet_next = {1'b0, quiet_ticks} + 9'd1;
    if (quiet_next <= {1'b0, gap_cfg}) begin
      quiet_ticks = quiet_next[7:0];
      return;
    end
    open_frame  = 1'b0;
    quiet_ticks = '0;
    n           = frame_len;
    frame_len   = '0;
    // short, overflowed or foreign frames vanish
    if (n < 3 || overrun || frame_mem[0] != addr_cfg) begin
      overrun = 1'b0;
      crc_acc = CRC_INIT;
      return;
    end
    if (crc_acc != 16'h0000) begin
      crc_acc = CRC_INIT;
      r = '{kind: KIND_ERROR, data: frame_mem[1], last: 1'b1};
      pending_results.push_back(r);
      return;
    end
    crc_acc = CRC_INIT;
    // good frame: length byte, then payload without the crc
    for (int unsigned i = 0; i < n - 2; i++) begin
      r.kind = KIND_DATA;
      r.data = (i == 0) ? 8'(n - 3) : frame_mem[i];
      r.last = (i == n - 3);
      pending_results.push_back(r);
    end
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: result %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches_o++;
    end
  endfunction

  // config writes, input items and result items, sampled at the edge
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      frame_len    = '0;
      open_frame   = 1'b0;
      quiet_ticks  = '0;
      crc_acc      = CRC_INIT;
      overrun      = 1'b0;
      addr_cfg     = 8'h00;
      gap_cfg      = GAP_RESET;
      mismatches_o = 0;
      pending_results.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_SLAVE_ID: addr_cfg = cfg_i.data;
          REG_GAP:      gap_cfg  = cfg_i.data;
          default: ;
        endcase
      end
      if (rx_i.valid && rx_i.ready) receive_item(rx_i.op, rx_i.rx_byte);
      if (res_i.valid && res_i.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual kind %0d byte %0h last %0d",
                   $time, res_i.kind, res_i.out_byte, res_i.last);
          mismatches_o++;
        end else begin
          want = pending_results.pop_front();
          compare_field("kind", 8'(want.kind), 8'(res_i.kind));
          compare_field("byte", want.data, res_i.out_byte);
          compare_field("last", 8'(want.last), 8'(res_i.last));
        end
      end
    end
    waiting_o = pending_results.size();
  end

endmodule

// File: verif/rtu_frame_receiver_crc_check_unit_test.sv
// rtu_frame_receiver_crc_check_unit_test: drives bytes, ticks and config writes
// into the frame receiver and gives the verdict; checking lives in rtu_frame_result_check
// depends on rtu_pkg, rtu_ifs, rtu_frame_result_check and the rtl top level

module rtu_frame_receiver_crc_check_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rtu_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned HOLD_AT       = 30;
  localparam int unsigned HOLD_CYCLES   = 300;

  typedef enum int unsigned {
    FR_GOOD, FR_BAD_CRC, FR_SHORT, FR_FOREIGN, FR_OVERRUN, FR_NOISE
  } frame_kind_e;

  typedef logic [7:0] octet_q_t [$];

  logic        clk;
  logic        rst_n;
  int unsigned mismatches;
  int unsigned results_waiting;
  int unsigned tx_calm = 0;
  int unsigned rx_calm = 0;
  int unsigned cycle_count = 0;
  logic [7:0]  addr_now = 8'h00;
  int unsigned gap_now = GAP_RESET;

  rtu_in_if  rx_ch ();
  rtu_out_if res_ch ();
  rtu_cfg_if cfg_ch ();

  rtu_frame_receiver_crc_check_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  rtu_frame_result_check frame_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .rx_i         (rx_ch),
    .res_i        (res_ch),
    .cfg_i        (cfg_ch),
    .mismatches_o (mismatches),
    .waiting_o    (results_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[rtu_frame_receiver_crc_check_unit] ERROR");
      $finish;
    end
  end

  // random wait before the next item, with calm stretches of none
  function automatic int unsigned idle_draw(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  // result side: random stalls, one long hold-off
  initial begin
    int unsigned taken;
    int unsigned w;
    taken = 0;
    res_ch.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      w = (taken == HOLD_AT) ? HOLD_CYCLES : idle_draw(rx_calm);
      if (w > 0) begin
        res_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
      taken++;
    end
  end

  task automatic send_item(input logic op, input logic [7:0] b);
    int unsigned w;
    w = idle_draw(tx_calm);
    if (w > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.op      <= op;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
  endtask

  // both registers in one burst, valid held between them
  task automatic write_config(input logic [7:0] addr, input logic [7:0] gap);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_SLAVE_ID;
    cfg_ch.data  <= addr;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= REG_GAP;
    cfg_ch.data  <= gap;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    addr_now = addr;
    gap_now  = gap;
  endtask

  // append crc, low byte first
  function automatic octet_q_t seal(input octet_q_t f);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (f[i]) begin
      c ^= {8'h00, f[i]};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    f.push_back(c[7:0]);
    f.push_back(c[15:8]);
    return f;
  endfunction

  function automatic frame_kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return FR_GOOD;
    if (r < 75) return FR_BAD_CRC;
    if (r < 82) return FR_SHORT;
    if (r < 89) return FR_FOREIGN;
    if (r < 93) return FR_OVERRUN;
    return FR_NOISE;
  endfunction

  // len of zero means a random length fitting the kind
  function automatic octet_q_t build_frame(input frame_kind_e kind, input int unsigned len);
    octet_q_t    f;
    int unsigned r;
    int unsigned pos;
    r = $urandom_range(0, 99);
    if (len == 0) begin
      case (kind)
        FR_SHORT:   len = $urandom_range(1, 2);
        FR_OVERRUN: len = $urandom_range(FRAME_DEPTH + 1, FRAME_DEPTH + 6);
        FR_NOISE:   len = $urandom_range(1, 6);
        default:    len = (r < 85) ? $urandom_range(3, 10) :
                          (r < 93) ? FRAME_DEPTH : $urandom_range(11, FRAME_DEPTH - 1);
      endcase
    end
    case (kind)
      FR_FOREIGN: f.push_back(addr_now ^ 8'($urandom_range(1, 255)));
      FR_NOISE:   f.push_back(8'($urandom));
      default:    f.push_back(addr_now);
    endcase
    if (kind == FR_SHORT || kind == FR_NOISE) begin
      while (f.size() < len) f.push_back(8'($urandom));
      return f;
    end
    while (f.size() < len - 2) f.push_back(8'($urandom));
    f = seal(f);
    // one flipped bit anywhere past the address
    if (kind == FR_BAD_CRC) begin
      pos = $urandom_range(1, f.size() - 1);
      f[pos] ^= 8'(1 << $urandom_range(0, 7));
    end
    return f;
  endfunction

  // bytes with random silence up to the gap, then enough ticks to close
  task automatic send_frame(input octet_q_t f);
    int unsigned r;
    int unsigned quiet;
    foreach (f[i]) begin
      if (i > 0) begin
        r = $urandom_range(0, 9);
        quiet = (r < 7) ? 0 : (r < 9) ? $urandom_range(1, (gap_now < 3) ? gap_now : 3) : gap_now;
        repeat (quiet) send_item(OP_TICK, 8'($urandom));
      end
      send_item(OP_BYTE, f[i]);
    end
    repeat (gap_now + 1) send_item(OP_TICK, 8'($urandom));
  endtask

  // sender pauses until every expected item is out and the block has settled
  task automatic drain();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] addr, input logic [7:0] gap,
                           input int unsigned frames, input frame_kind_e opener,
                           input int unsigned opener_len);
    write_config(addr, gap);
    send_frame(build_frame(opener, opener_len));
    repeat (frames) send_frame(build_frame(pick_kind(), 0));
    drain();
  endtask

  // stimulus
  initial begin
    octet_q_t f;
    rst_n         <= 1'b0;
    rx_ch.valid   <= 1'b0;
    rx_ch.op      <= OP_TICK;
    rx_ch.rx_byte <= 8'h00;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= REG_SLAVE_ID;
    cfg_ch.data   <= 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: gap of one, address zero
    write_config(8'h00, 8'd1);
    send_item(OP_TICK, 8'hFF);
    // shortest good frame, payload length zero
    f.delete();
    f.push_back(8'h00);
    send_frame(seal(f));
    // crc error carrying an all-ones function code
    f.push_back(8'hFF);
    f = seal(f);
    f[3] ^= 8'h80;
    send_frame(f);
    // two bytes only
    f.delete();
    f.push_back(8'h00);
    f.push_back(8'h80);
    send_frame(f);
    // frame for another address
    f.delete();
    f.push_back(8'h01);
    f.push_back(8'h02);
    send_frame(seal(f));
    drain();

    // longest gap: shortest good frame, closed by the 256th silent tick
    run_phase(8'hFF, 8'd255, 0, FR_GOOD, 3);

    // overrun, then a frame that fills the buffer exactly, then a random one
    write_config(8'h5A, 8'd1);
    send_frame(build_frame(FR_OVERRUN, 0));
    send_frame(build_frame(FR_GOOD, FRAME_DEPTH));
    send_frame(build_frame(pick_kind(), 0));
    drain();

    // random frames under a short random gap
    run_phase(8'($urandom), 8'($urandom_range(1, 4)), 2, FR_BAD_CRC, 0);

    if (mismatches == 0 && results_waiting == 0) begin
      $display("[rtu_frame_receiver_crc_check_unit] OK");
    end else begin
      $display("[rtu_frame_receiver_crc_check_unit] ERROR");
    end
    $finish;
  end

endmodule
